>>> hdl/hcfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcfr_pkg
// Shared types, register indexes, reset values and the CRC-16-CCITT byte
// update for the header CRC frame receiver.
// ----------------------------------------------------------------------------
package hcfr_pkg;

   // Frame geometry
   localparam int          MAX_FRAME_LENGTH_DEFAULT = 255;
   localparam logic [7:0]  MIN_FRAME_LENGTH         = 8'd4;

   // Register reset values
   localparam logic [15:0] HEADER_WORD_RESET  = 16'hA5A0;
   localparam logic [7:0]  FRAME_LENGTH_RESET = 8'd30;

   // CRC-16-CCITT, MSB first, no reflection, no final XOR
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   // Configuration register indexes
   localparam int          CSR_INDEX_WIDTH   = 2;
   localparam int          CSR_DATA_WIDTH    = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_WORD  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_LENGTH = 2'd1;

   // Item command codes
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Input beat
   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [1:0] receiver_state;
      logic       frame_good;
      logic       crc_mismatch;
   } rsp_type;

   // Fold one byte into the running CRC (eight shift steps, unrolled)
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> hdl/header_crc_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_crc_frame_receiver
// Fixed-length frame receiver: two-byte header, running CRC-16-CCITT over
// all bytes but the last two, which carry the expected CRC high byte first.
// ----------------------------------------------------------------------------
// The byte-wide CRC update and receiver state machine are combinational;
// each accepted beat's result goes to the output register, or the skid
// register if full, so a new beat can be taken every cycle while req_ready
// is high. A two-entry output stage (output register plus skid register)
// keeps the input side running while a result waits; req_ready drops only
// when both entries are full. Configuration registers are written through
// the csr_ channel, which is always ready; write them only while the block
// is idle. A frame_length below 4 acts as 4, one above MAX_FRAME_LENGTH acts
// as MAX_FRAME_LENGTH. After a good frame the receiver stays completed and
// ignores bytes until a restart beat arrives.
// ----------------------------------------------------------------------------
module header_crc_frame_receiver #(
   parameter int MAX_FRAME_LENGTH = hcfr_pkg::MAX_FRAME_LENGTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input beats
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  hcfr_pkg::req_type                    req_data,
   // result beats
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output hcfr_pkg::rsp_type                    rsp_data,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hcfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hcfr_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   import hcfr_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_LENGTH);

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_STARTED   = 2'd1,
      ST_RECEIVING = 2'd2,
      ST_COMPLETED = 2'd3
   } state_type;

   // Configuration registers
   logic [15:0] header_word_ff;
   logic [7:0]  frame_length_ff;

   // Receiver state
   state_type   state_ff, state_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  check_hi_ff, check_hi_in;

   // Output stage
   logic        out_valid_ff;
   rsp_type     out_data_ff;
   logic        skid_valid_ff;
   rsp_type     skid_data_ff;

   logic        req_fire;
   logic        rsp_fire;
   logic [7:0]  eff_len;
   logic        good;
   logic        bad;
   rsp_type     result;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign rsp_fire  = out_valid_ff && rsp_ready;

   // Clamp the frame length into its legal range
   always_comb begin
      eff_len = frame_length_ff;
      if (eff_len < MIN_FRAME_LENGTH) begin
         eff_len = MIN_FRAME_LENGTH;
      end
      if (eff_len > MAX_LEN) begin
         eff_len = MAX_LEN;
      end
   end

   // Work out the next receiver state and the flags for this beat
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      check_hi_in = check_hi_ff;
      good        = 1'b0;
      bad         = 1'b0;
      if (req_data.cmd == CMD_RESTART) begin
         state_in = ST_IDLE;
         count_in = 8'd0;
         crc_in   = CRC_INIT;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_data.rx_byte == header_word_ff[15:8]) begin
                  crc_in   = crc_byte(CRC_INIT, req_data.rx_byte);
                  count_in = 8'd1;
                  state_in = ST_STARTED;
               end
            end
            ST_STARTED: begin
               if (req_data.rx_byte == header_word_ff[7:0]) begin
                  crc_in   = crc_byte(crc_ff, req_data.rx_byte);
                  count_in = 8'd2;
                  state_in = ST_RECEIVING;
               end else begin
                  state_in = ST_IDLE;
                  count_in = 8'd0;
                  crc_in   = CRC_INIT;
               end
            end
            ST_RECEIVING: begin
               if (count_ff >= eff_len - 8'd1) begin
                  // final CRC byte: compare against the running value
                  if ({check_hi_ff, req_data.rx_byte} == crc_ff) begin
                     state_in = ST_COMPLETED;
                     count_in = count_ff + 8'd1;
                     good     = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                     count_in = 8'd0;
                     crc_in   = CRC_INIT;
                     bad      = 1'b1;
                  end
               end else begin
                  if (count_ff == eff_len - 8'd2) begin
                     check_hi_in = req_data.rx_byte;
                  end else begin
                     crc_in = crc_byte(crc_ff, req_data.rx_byte);
                  end
                  count_in = count_ff + 8'd1;
               end
            end
            default: begin
               // completed: ignore bytes until restart
            end
         endcase
      end
      result.receiver_state = state_in;
      result.frame_good     = good;
      result.crc_mismatch   = bad;
   end

   // Hold state, configuration and the output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         header_word_ff  <= HEADER_WORD_RESET;
         frame_length_ff <= FRAME_LENGTH_RESET;
         state_ff        <= ST_IDLE;
         count_ff        <= 8'd0;
         crc_ff          <= CRC_INIT;
         check_hi_ff     <= 8'd0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEADER_WORD:  header_word_ff  <= csr_wdata;
               CSR_FRAME_LENGTH: frame_length_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end

         // advance the receiver on each accepted beat
         if (req_fire) begin
            state_ff    <= state_in;
            count_ff    <= count_in;
            crc_ff      <= crc_in;
            check_hi_ff <= check_hi_in;
         end

         // output register with skid entry behind it
         if (rsp_fire) begin
            if (skid_valid_ff) begin
               out_data_ff   <= skid_data_ff;
               skid_valid_ff <= 1'b0;
            end else if (req_fire) begin
               out_data_ff <= result;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end else if (req_fire) begin
            if (out_valid_ff) begin
               skid_data_ff  <= result;
               skid_valid_ff <= 1'b1;
            end else begin
               out_data_ff  <= result;
               out_valid_ff <= 1'b1;
            end
         end
      end
   end

endmodule
